// ===== rtl/fsf_pkg.sv =====
// fsf_pkg: shared constants for the framebuffer shape fill engine
// sizes of the frame store, field widths, command and register codes
// no dependencies
package fsf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 32;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 16;
  localparam int SIZE_W    = 15;
  localparam int COLOR_W   = 32;

  // signed box bounds, shared multiplier operands and products
  localparam int BND_W  = 18;
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIST_W = 32;

  localparam logic [FUNC_W-1:0] FN_FILL   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RECT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CRECT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CIRCLE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;

endpackage

// ===== rtl/fsf_ram.sv =====
// fsf_ram: generic single-port RAM with registered read data
// no dependencies
module fsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/fsf_mul.sv =====
// fsf_mul: shared signed multiplier with registered product
// depends on fsf_pkg for operand widths
module fsf_mul (
  input  logic                              clk,
  input  logic signed [fsf_pkg::MUL_W-1:0]  a,
  input  logic signed [fsf_pkg::MUL_W-1:0]  b,
  output logic signed [fsf_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/framebuffer_shape_fill.sv =====
// framebuffer_shape_fill: clipped fill, rectangle, circle and pixel read engine
// a read clips, multiplies the row address, reads the store and waits for the data; paint scans
// the clipped box one pixel per cycle within a row, after per-row steps on the shared multiplier
// (dy squared, dx squared, sum); empty box, out-of-frame read or unused code skip to done
// one command at a time; in_stall stays high until the result is in the output register
// synchronous active-low reset clears control and sets 256 x 256; store undefined until painted
module framebuffer_shape_fill (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [fsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsf_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fsf_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [fsf_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [fsf_pkg::POS_W-1:0]   in_pos_y,
  input  logic [fsf_pkg::SIZE_W-1:0]         in_size_w,
  input  logic [fsf_pkg::SIZE_W-1:0]         in_size_h,
  input  logic [fsf_pkg::SIZE_W-1:0]         in_radius,
  input  logic [fsf_pkg::COLOR_W-1:0]        in_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fsf_pkg::COLOR_W-1:0]        out_read_color,
  output logic                               out_read_in_frame
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLIP, S_BASE, S_RSQ, S_R2, S_ROW, S_ROWX, S_ROWD, S_PIX,
    S_RD_MUL, S_RD_ADDR, S_RD_WAIT, S_DONE
  } state_t;

  localparam int BND_W  = fsf_pkg::BND_W;
  localparam int MUL_W  = fsf_pkg::MUL_W;
  localparam int POS_W  = fsf_pkg::POS_W;
  localparam int SIZE_W = fsf_pkg::SIZE_W;
  localparam int XW     = fsf_pkg::XW;
  localparam int YW     = fsf_pkg::YW;
  localparam int ADDR_W = fsf_pkg::ADDR_W;
  localparam int DIST_W = fsf_pkg::DIST_W;
  localparam int DIM_W  = fsf_pkg::DIM_W;
  localparam int DIMH_W = fsf_pkg::DIMH_W;
  localparam int PIX_W  = fsf_pkg::PIXEL_BITS;

  state_t state_r, state_nxt;

  logic [fsf_pkg::CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [fsf_pkg::CFG_W-1:0] frame_height_r, frame_height_nxt;

  logic [fsf_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic signed [POS_W-1:0]    px_r, px_nxt;
  logic signed [POS_W-1:0]    py_r, py_nxt;
  logic [SIZE_W-1:0]          rad_r, rad_nxt;
  logic [PIX_W-1:0]           color_r, color_nxt;
  logic signed [BND_W-1:0]    xa_r, xa_nxt, xb_r, xb_nxt, ya_r, ya_nxt, yb_r, yb_nxt;
  logic [XW-1:0]              xs_r, xs_nxt, xe_r, xe_nxt;
  logic [YW-1:0]              ys_r, ys_nxt, ye_r, ye_nxt;
  logic [XW-1:0]              scan_col_r, scan_col_nxt;
  logic [YW-1:0]              scan_row_r, scan_row_nxt;
  logic [ADDR_W-1:0]          base_r, base_nxt;
  logic [DIST_W-1:0]          r2_r, r2_nxt, dy2_r, dy2_nxt, d_r, d_nxt;
  logic signed [MUL_W-1:0]    dx_r, dx_nxt;
  logic [fsf_pkg::COLOR_W-1:0] res_color_r, res_color_nxt;
  logic                       res_inf_r, res_inf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [fsf_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;
  logic                       out_inf_r, out_inf_nxt;

  logic [DIM_W-1:0]           w_eff;
  logic [DIMH_W-1:0]          h_eff;
  logic signed [BND_W-1:0]    w_b, h_b, wm1_b, hm1_b;
  logic signed [BND_W-1:0]    px_in_b, py_in_b, sw_b, sh_b, r_b;
  logic signed [BND_W-1:0]    cxa, cxb, cya, cyb;
  logic signed [BND_W-1:0]    cx_s, cx_e, cy_s, cy_e, px_b, py_b;
  logic                       box_empty, rd_in_frame;
  logic signed [MUL_W-1:0]    px_m, py_m, row_m, col_m, xs_m, w_m, r_m;
  logic signed [MUL_W-1:0]    dy_m, dx0_m;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [fsf_pkg::PROD_W-1:0] mul_p;
  logic                       pix_hit;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [PIX_W-1:0]           ram_rdata;
  logic                       in_accept, out_free;

  fsf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fsf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (fsf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (color_r),
    .rdata (ram_rdata)
  );

  // effective frame size saturates at the store dimensions
  assign w_eff = (32'(frame_width_r) > fsf_pkg::MAX_WIDTH) ?
                 DIM_W'(fsf_pkg::MAX_WIDTH) : DIM_W'(frame_width_r);
  assign h_eff = (32'(frame_height_r) > fsf_pkg::MAX_HEIGHT) ?
                 DIMH_W'(fsf_pkg::MAX_HEIGHT) : DIMH_W'(frame_height_r);
  assign w_b   = {{(BND_W-DIM_W){1'b0}}, w_eff};
  assign h_b   = {{(BND_W-DIMH_W){1'b0}}, h_eff};
  assign wm1_b = w_b - BND_W'(1);
  assign hm1_b = h_b - BND_W'(1);

  // raw box bounds from the incoming command
  assign px_in_b = {{(BND_W-POS_W){in_pos_x[POS_W-1]}}, in_pos_x};
  assign py_in_b = {{(BND_W-POS_W){in_pos_y[POS_W-1]}}, in_pos_y};
  assign sw_b    = {{(BND_W-SIZE_W){1'b0}}, in_size_w};
  assign sh_b    = {{(BND_W-SIZE_W){1'b0}}, in_size_h};
  assign r_b     = {{(BND_W-SIZE_W){1'b0}}, in_radius};

  always_comb begin
    cxa = '0;
    cxb = '0;
    cya = '0;
    cyb = '0;
    case (in_func)
      fsf_pkg::FN_FILL: begin
        cxb = wm1_b;
        cyb = hm1_b;
      end
      fsf_pkg::FN_RECT: begin
        cxa = px_in_b;
        cxb = px_in_b + sw_b - BND_W'(1);
        cya = py_in_b;
        cyb = py_in_b + sh_b - BND_W'(1);
      end
      fsf_pkg::FN_CRECT: begin
        cxa = px_in_b - (sw_b >> 1);
        cxb = px_in_b - (sw_b >> 1) + sw_b - BND_W'(1);
        cya = py_in_b - (sh_b >> 1);
        cyb = py_in_b - (sh_b >> 1) + sh_b - BND_W'(1);
      end
      fsf_pkg::FN_CIRCLE: begin
        cxa = px_in_b - r_b;
        cxb = px_in_b + r_b;
        cya = py_in_b - r_b;
        cyb = py_in_b + r_b;
      end
      default: begin
        cxa = '0;
      end
    endcase
  end

  // clip to the active frame
  assign cx_s = (xa_r < 0) ? '0 : xa_r;
  assign cy_s = (ya_r < 0) ? '0 : ya_r;
  assign cx_e = (xb_r > wm1_b) ? wm1_b : xb_r;
  assign cy_e = (yb_r > hm1_b) ? hm1_b : yb_r;
  assign box_empty = (cx_s > cx_e) || (cy_s > cy_e);

  assign px_b = {{(BND_W-POS_W){px_r[POS_W-1]}}, px_r};
  assign py_b = {{(BND_W-POS_W){py_r[POS_W-1]}}, py_r};
  assign rd_in_frame = (px_b >= 0) && (px_b < w_b) && (py_b >= 0) && (py_b < h_b);

  // shared multiplier operands
  assign px_m  = {{(MUL_W-POS_W){px_r[POS_W-1]}}, px_r};
  assign py_m  = {{(MUL_W-POS_W){py_r[POS_W-1]}}, py_r};
  assign row_m = {{(MUL_W-YW){1'b0}}, scan_row_r};
  assign col_m = {{(MUL_W-YW){1'b0}}, ys_r};
  assign xs_m  = {{(MUL_W-XW){1'b0}}, xs_r};
  assign w_m   = {{(MUL_W-DIM_W){1'b0}}, w_eff};
  assign r_m   = {{(MUL_W-SIZE_W){1'b0}}, rad_r};
  assign dy_m  = row_m - py_m;
  assign dx0_m = xs_m - px_m;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_BASE: begin
        mul_a = col_m;
        mul_b = w_m;
      end
      S_RSQ: begin
        mul_a = r_m;
        mul_b = r_m;
      end
      S_ROW: begin
        mul_a = dy_m;
        mul_b = dy_m;
      end
      S_ROWX: begin
        mul_a = dx0_m;
        mul_b = dx0_m;
      end
      S_RD_MUL: begin
        mul_a = {{(MUL_W-YW){1'b0}}, py_r[YW-1:0]};
        mul_b = w_m;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign pix_hit = (func_r != fsf_pkg::FN_CIRCLE) || (d_r <= r2_r);
  assign ram_we  = (state_r == S_PIX) && pix_hit;
  assign ram_addr = (state_r == S_PIX) ? (base_r + ADDR_W'(scan_col_r)) :
                    (mul_p[ADDR_W-1:0] + ADDR_W'(px_r[XW-1:0]));

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    func_nxt         = func_r;
    px_nxt           = px_r;
    py_nxt           = py_r;
    rad_nxt          = rad_r;
    color_nxt        = color_r;
    xa_nxt           = xa_r;
    xb_nxt           = xb_r;
    ya_nxt           = ya_r;
    yb_nxt           = yb_r;
    xs_nxt           = xs_r;
    xe_nxt           = xe_r;
    ys_nxt           = ys_r;
    ye_nxt           = ye_r;
    scan_col_nxt     = scan_col_r;
    scan_row_nxt     = scan_row_r;
    base_nxt         = base_r;
    r2_nxt           = r2_r;
    dy2_nxt          = dy2_r;
    d_nxt            = d_r;
    dx_nxt           = dx_r;
    res_color_nxt    = res_color_r;
    res_inf_nxt      = res_inf_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_color_nxt    = out_color_r;
    out_inf_nxt      = out_inf_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        fsf_pkg::CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        fsf_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        default: frame_width_nxt = frame_width_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          func_nxt      = in_func;
          px_nxt        = in_pos_x;
          py_nxt        = in_pos_y;
          rad_nxt       = in_radius;
          color_nxt     = in_color[PIX_W-1:0];
          xa_nxt        = cxa;
          xb_nxt        = cxb;
          ya_nxt        = cya;
          yb_nxt        = cyb;
          res_color_nxt = '0;
          res_inf_nxt   = 1'b0;
          state_nxt     = S_CLIP;
        end
      end
      S_CLIP: begin
        xs_nxt = cx_s[XW-1:0];
        xe_nxt = cx_e[XW-1:0];
        ys_nxt = cy_s[YW-1:0];
        ye_nxt = cy_e[YW-1:0];
        scan_row_nxt = cy_s[YW-1:0];
        case (func_r) inside
          fsf_pkg::FN_FILL, fsf_pkg::FN_RECT, fsf_pkg::FN_CRECT, fsf_pkg::FN_CIRCLE: begin
            state_nxt = box_empty ? S_DONE : S_BASE;
          end
          fsf_pkg::FN_READ: begin
            state_nxt = rd_in_frame ? S_RD_MUL : S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BASE: begin
        state_nxt = S_RSQ;
      end
      S_RSQ: begin
        base_nxt  = mul_p[ADDR_W-1:0];
        state_nxt = S_R2;
      end
      S_R2: begin
        r2_nxt    = mul_p[DIST_W-1:0];
        state_nxt = S_ROW;
      end
      S_ROW: begin
        state_nxt = S_ROWX;
      end
      S_ROWX: begin
        dy2_nxt   = mul_p[DIST_W-1:0];
        state_nxt = S_ROWD;
      end
      S_ROWD: begin
        d_nxt        = dy2_r + mul_p[DIST_W-1:0];
        dx_nxt       = dx0_m;
        scan_col_nxt = xs_r;
        state_nxt    = S_PIX;
      end
      S_PIX: begin
        if (scan_col_r == xe_r) begin
          if (scan_row_r == ye_r) begin
            state_nxt = S_DONE;
          end else begin
            scan_row_nxt = scan_row_r + YW'(1);
            base_nxt     = base_r + ADDR_W'(w_eff);
            state_nxt    = S_ROW;
          end
        end else begin
          scan_col_nxt = scan_col_r + XW'(1);
          dx_nxt       = dx_r + MUL_W'(1);
          // (dx + 1)^2 = dx^2 + 2 dx + 1
          d_nxt = d_r + {{(DIST_W-MUL_W-1){dx_r[MUL_W-1]}}, dx_r, 1'b1};
        end
      end
      S_RD_MUL: begin
        state_nxt = S_RD_ADDR;
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        res_color_nxt = fsf_pkg::COLOR_W'(ram_rdata);
        res_inf_nxt   = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        scan_col_nxt = '0;
        scan_row_nxt = '0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = res_color_r;
          out_inf_nxt   = res_inf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_width_r  <= fsf_pkg::FRAME_WIDTH_RST;
      frame_height_r <= fsf_pkg::FRAME_HEIGHT_RST;
      scan_col_r     <= '0;
      scan_row_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      scan_col_r     <= scan_col_nxt;
      scan_row_r     <= scan_row_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    func_r      <= func_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    rad_r       <= rad_nxt;
    color_r     <= color_nxt;
    xa_r        <= xa_nxt;
    xb_r        <= xb_nxt;
    ya_r        <= ya_nxt;
    yb_r        <= yb_nxt;
    xs_r        <= xs_nxt;
    xe_r        <= xe_nxt;
    ys_r        <= ys_nxt;
    ye_r        <= ye_nxt;
    base_r      <= base_nxt;
    r2_r        <= r2_nxt;
    dy2_r       <= dy2_nxt;
    d_r         <= d_nxt;
    dx_r        <= dx_nxt;
    res_color_r <= res_color_nxt;
    res_inf_r   <= res_inf_nxt;
    out_color_r <= out_color_nxt;
    out_inf_r   <= out_inf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_color    = out_color_r;
  assign out_read_in_frame = out_inf_r;

`ifndef SYNTHESIS
  a_accept_to_clip: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_CLIP))
    else $error("accepted transaction did not start clipping");

  a_col_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX) |-> (scan_col_r >= xs_r) && (scan_col_r <= xe_r))
    else $error("scan column left the clipped box");

  a_row_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX) |-> (scan_row_r >= ys_r) && (scan_row_r <= ye_r))
    else $error("scan row left the clipped box");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without finishing a command");

  a_color_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_color_r != '0)) |-> out_inf_r)
    else $error("nonzero read color outside the frame");
`endif

endmodule
